@@ sv/erm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_pkg: shared types and constants of the Euclidean rhythm mask block
// Field widths, sequencer states and the control words that pass between
// the sequencer, the shared divider and the pattern expander.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int VAL_W      = 5;
    localparam int ROT_W      = 4;
    localparam int MASK_W     = 16;
    localparam int MASK_IDX_W = 4;
    // Euclid chains on values below 32 stay far below this many levels
    localparam int LVL_CAP    = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ROT,
        ST_EUC,
        ST_EUC_WAIT,
        ST_EXP_GO,
        ST_EXP,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quotient;
        logic [VAL_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic go;
        logic wr_en;
        logic wr_nz;
    } exp_ctl_t;

endpackage

@@ sv/erm_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_divider: shared compare-and-subtract divider
// Repeated subtraction, one compare and subtract per cycle. Gives quotient
// and remainder with a one-cycle done pulse. The divisor is never zero.
// ----------------------------------------------------------------------------
module erm_divider
    import erm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             run_reg;
    logic [VAL_W-1:0] acc_reg;
    logic [VAL_W-1:0] quo_reg;
    logic [VAL_W-1:0] dsr_reg;
    logic             fits;

    always_comb
    begin
        fits          = acc_reg >= dsr_reg;
        rsp.done      = run_reg && !fits;
        rsp.quotient  = quo_reg;
        rsp.remainder = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (req.start)
        begin
            run_reg <= 1'b1;
        end
        else if (run_reg && !fits)
        begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= req.dividend;
            dsr_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (run_reg && fits)
        begin
            acc_reg <= acc_reg - dsr_reg;
            quo_reg <= quo_reg + 1'b1;
        end
    end

endmodule

@@ sv/erm_expander.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_expander: nested pattern walk
// Holds the repeat count of each level and walks the nested pattern from
// the deepest level, one frame step per cycle, with a return-distance stack.
// Each emitted hit sets its rotated bit in the mask.
// ----------------------------------------------------------------------------
module erm_expander
    import erm_pkg::*;
#(
    parameter int MAX_STEPS = 16,
    parameter int LVL_SLOTS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  exp_ctl_t                     ctl,
    input  logic [$clog2(LVL_SLOTS)-1:0] wr_lvl,
    input  logic [VAL_W-1:0]             wr_reps,
    input  logic [$clog2(LVL_SLOTS)-1:0] top_lvl,
    input  logic [VAL_W-1:0]             steps,
    input  logic [VAL_W-1:0]             rot_mod,
    output logic                         done,
    output logic [MASK_W-1:0]            mask
);

    localparam int LVL_W = $clog2(LVL_SLOTS);
    localparam int LEN_W = $clog2(MAX_STEPS + 1);
    localparam int CMP_W = VAL_W + 1;

    logic                 run_reg;
    logic [LVL_W-1:0]     cur_reg;
    logic [LVL_W-1:0]     top_reg;
    logic [LVL_SLOTS-1:0] stk_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [VAL_W-1:0]     pos_reg;
    logic [VAL_W-1:0]     steps_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic [VAL_W-1:0]     k_reg    [LVL_SLOTS];
    logic                 ph_reg   [LVL_SLOTS];
    logic [VAL_W-1:0]     reps_reg [LVL_SLOTS];
    logic                 nz_reg   [LVL_SLOTS];

    logic [VAL_W-1:0]     k_c;
    logic                 ph_c;
    logic [VAL_W-1:0]     reps_c;
    logic                 nz_c;
    logic                 room;
    logic                 loop_more;
    logic                 frame_wr;
    logic [VAL_W-1:0]     k_next;
    logic                 ph_next;
    logic                 leaf;
    logic                 leaf_hit;
    logic                 push;
    logic                 push_bit;
    logic                 pop;
    logic                 finish;
    logic [LVL_W-1:0]     cur_next;
    logic                 in_range;
    logic [VAL_W-1:0]     pos_inc;

    always_comb
    begin
        k_c       = k_reg[cur_reg];
        ph_c      = ph_reg[cur_reg];
        reps_c    = reps_reg[cur_reg];
        nz_c      = nz_reg[cur_reg];
        room      = len_reg < LEN_W'(MAX_STEPS);
        loop_more = (k_c < reps_c) && room;
        frame_wr  = 1'b0;
        k_next    = k_c;
        ph_next   = ph_c;
        leaf      = 1'b0;
        leaf_hit  = 1'b0;
        push      = 1'b0;
        push_bit  = 1'b0;
        pop       = 1'b0;
        finish    = 1'b0;
        cur_next  = cur_reg;
        if (run_reg)
        begin
            frame_wr = 1'b1;
            if (!ph_c)
            begin
                if (loop_more)
                begin
                    // one more repeat of the level below; level zero repeats a rest
                    k_next = k_c + 1'b1;
                    if (cur_reg == '0)
                    begin
                        leaf = 1'b1;
                    end
                    else
                    begin
                        push     = 1'b1;
                        cur_next = cur_reg - LVL_W'(1);
                    end
                end
                else
                begin
                    // repeats done: take the remainder branch, if any, two levels down (a leaf at levels one and zero)
                    ph_next = 1'b1;
                    if (nz_c)
                    begin
                        if (cur_reg == '0)
                        begin
                            leaf     = 1'b1;
                            leaf_hit = 1'b1;
                        end
                        else if (cur_reg == LVL_W'(1))
                        begin
                            leaf = 1'b1;
                        end
                        else
                        begin
                            push     = 1'b1;
                            push_bit = 1'b1;
                            cur_next = cur_reg - LVL_W'(2);
                        end
                    end
                end
            end
            else
            begin
                // leave the frame clean for its next call
                k_next  = '0;
                ph_next = 1'b0;
                if (cur_reg == top_reg)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    pop      = 1'b1;
                    cur_next = stk_reg[0] ? cur_reg + LVL_W'(2) : cur_reg + LVL_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        in_range = CMP_W'(len_reg) < CMP_W'(steps_reg);
        pos_inc  = pos_reg + 1'b1;
        done     = finish;
        mask     = mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (ctl.go)
        begin
            run_reg <= 1'b1;
        end
        else if (finish)
        begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            reps_reg[wr_lvl] <= wr_reps;
            nz_reg[wr_lvl]   <= ctl.wr_nz;
        end
        if (ctl.go)
        begin
            cur_reg   <= top_lvl;
            top_reg   <= top_lvl;
            stk_reg   <= '0;
            len_reg   <= '0;
            pos_reg   <= rot_mod;
            steps_reg <= steps;
            mask_reg  <= '0;
            for (int i = 0; i < LVL_SLOTS; i++)
            begin
                k_reg[i]  <= '0;
                ph_reg[i] <= 1'b0;
            end
        end
        else
        begin
            cur_reg <= cur_next;
            if (frame_wr)
            begin
                k_reg[cur_reg]  <= k_next;
                ph_reg[cur_reg] <= ph_next;
            end
            if (push)
            begin
                stk_reg <= {stk_reg[LVL_SLOTS-2:0], push_bit};
            end
            else if (pop)
            begin
                stk_reg <= {1'b0, stk_reg[LVL_SLOTS-1:1]};
            end
            if (leaf && room)
            begin
                if (leaf_hit && in_range && (pos_reg < VAL_W'(MASK_W)))
                begin
                    mask_reg[pos_reg[MASK_IDX_W-1:0]] <= 1'b1;
                end
                len_reg <= len_reg + 1'b1;
                pos_reg <= (pos_inc == steps_reg) ? '0 : pos_inc;
            end
        end
    end

endmodule

@@ sv/euclidean_rhythm_mask.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_rhythm_mask: Euclidean (Bjorklund) trigger mask generator
// Spreads a hit count as evenly as possible over a step count, rotates the
// result and returns it as a trigger mask of up to 16 steps.
//
//  channel  | signals                                | handshake
//  ---------+----------------------------------------+--------------------------
//  command  | step_count, hit_count, rotation        | start high, busy low
//  result   | beat_mask                              | done high for one cycle
//
// A word whose hit count is zero or covers every step goes from the check state
// straight to done; other words run the divider (one subtract per cycle over the
// rotation and each Euclid level) and then the expander (one frame step per cycle).
// Reset is asynchronous, active low, and returns the sequencer to idle; no
// clearing pass. start is ignored while busy; the receiver cannot stall, so
// the mask is shown with done for exactly one cycle.
// ----------------------------------------------------------------------------
module euclidean_rhythm_mask
    import erm_pkg::*;
#(
    parameter int MAX_STEPS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [VAL_W-1:0]  step_count,
    input  logic [VAL_W-1:0]  hit_count,
    input  logic [ROT_W-1:0]  rotation,
    output logic              busy,
    output logic              done,
    output logic [MASK_W-1:0] beat_mask
);

    localparam int LVL_SLOTS = (MAX_STEPS + 2 < LVL_CAP) ? MAX_STEPS + 2 : LVL_CAP;
    localparam int LVL_W     = $clog2(LVL_SLOTS);
    localparam int CMP_W     = VAL_W + 1;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [VAL_W-1:0]  steps_reg;
    logic [VAL_W-1:0]  hits_reg;
    logic [ROT_W-1:0]  rot_reg;
    logic [VAL_W-1:0]  rotm_reg;
    logic [VAL_W-1:0]  div_reg;
    logic [VAL_W-1:0]  rem_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [MASK_W-1:0] result_reg;

    logic              accept;
    logic [VAL_W-1:0]  steps_sat;
    logic              trivial;
    logic              more;
    logic [MASK_W-1:0] ones;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    exp_ctl_t          exp_ctl;
    logic [VAL_W-1:0]  exp_reps;
    logic              exp_done;
    logic [MASK_W-1:0] exp_mask;

    always_comb
    begin
        accept    = start && !busy;
        steps_sat = (CMP_W'(step_count) > CMP_W'(MAX_STEPS)) ? VAL_W'(MAX_STEPS)
                                                             : step_count;
        trivial   = (steps_reg == '0) || (hits_reg == '0) || (hits_reg >= steps_reg);
        more      = (rem_reg > VAL_W'(1)) && (lvl_reg < LVL_W'(LVL_SLOTS - 1));
        for (int j = 0; j < MASK_W; j++)
        begin
            ones[j] = VAL_W'(j) < steps_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = trivial ? ST_DONE : ST_ROT;
            end
            ST_ROT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_EUC;
                end
            end
            ST_EUC:
            begin
                state_next = more ? ST_EUC_WAIT : ST_EXP_GO;
            end
            ST_EUC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_EUC;
                end
            end
            ST_EXP_GO:
            begin
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                if (exp_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and unit control
    always_comb
    begin
        busy             = state_reg != ST_IDLE;
        done             = state_reg == ST_DONE;
        beat_mask        = result_reg;
        div_req.start    = ((state_reg == ST_CHECK) && !trivial)
                           || ((state_reg == ST_EUC) && more);
        div_req.dividend = (state_reg == ST_CHECK) ? VAL_W'(rot_reg) : div_reg;
        div_req.divisor  = (state_reg == ST_CHECK) ? steps_reg : rem_reg;
        exp_ctl.go       = state_reg == ST_EXP_GO;
        exp_ctl.wr_en    = ((state_reg == ST_EUC) && !more)
                           || ((state_reg == ST_EUC_WAIT) && div_rsp.done);
        exp_ctl.wr_nz    = (state_reg == ST_EUC_WAIT) || (rem_reg != '0);
        exp_reps         = (state_reg == ST_EUC_WAIT) ? div_rsp.quotient : div_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            steps_reg <= steps_sat;
            hits_reg  <= hit_count;
            rot_reg   <= rotation;
        end
        if (state_reg == ST_CHECK)
        begin
            result_reg <= ((steps_reg == '0) || (hits_reg == '0)) ? '0 : ones;
            rem_reg    <= hits_reg;
            div_reg    <= steps_reg - hits_reg;
            lvl_reg    <= '0;
        end
        if ((state_reg == ST_ROT) && div_rsp.done)
        begin
            rotm_reg <= div_rsp.remainder;
        end
        if ((state_reg == ST_EUC_WAIT) && div_rsp.done)
        begin
            // step down one Euclid level
            div_reg <= rem_reg;
            rem_reg <= div_rsp.remainder;
            lvl_reg <= lvl_reg + 1'b1;
        end
        if ((state_reg == ST_EXP) && exp_done)
        begin
            result_reg <= exp_mask;
        end
    end

    erm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    erm_expander #(
        .MAX_STEPS (MAX_STEPS),
        .LVL_SLOTS (LVL_SLOTS)
    ) u_expander (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (exp_ctl),
        .wr_lvl  (lvl_reg),
        .wr_reps (exp_reps),
        .top_lvl (lvl_reg),
        .steps   (steps_reg),
        .rot_mod (rotm_reg),
        .done    (exp_done),
        .mask    (exp_mask)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((beat_mask >> steps_reg) == '0))
        else $error("mask bit set at or above the step count");

endmodule
